FILE: hw/rtl/ufd_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
package ufd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 21;
    localparam int unsigned HeldW  = 2;
    localparam int unsigned LenW   = 3;
    localparam int unsigned NHeld  = 3;

    // Sequence lengths
    localparam logic [LenW-1:0] SEQ_LEN_2 = 3'd2;
    localparam logic [LenW-1:0] SEQ_LEN_3 = 3'd3;
    localparam logic [LenW-1:0] SEQ_LEN_4 = 3'd4;

    // Smallest legal value per length (anything below is overlong)
    localparam logic [CpW-1:0] FLOOR_2 = 21'h00080;
    localparam logic [CpW-1:0] FLOOR_3 = 21'h00800;
    localparam logic [CpW-1:0] FLOOR_4 = 21'h10000;

    localparam logic [ByteW-1:0] CONT_MASK = 8'h3F;

    typedef logic [NHeld-1:0][ByteW-1:0] ufd_held_t;

    typedef struct packed {
        logic [HeldW-1:0] bytes_held;
        logic [LenW-1:0]  seq_len;
    } ufd_state_t;

    typedef struct packed {
        logic             emit;
        logic [CpW-1:0]   code_point;
        logic             hb_we;
        logic [HeldW-1:0] hb_idx;
    } ufd_step_t;

endpackage

FILE: hw/rtl/ufd_step.sv
// One decode step: byte plus sequence state in, next state and result out.
module ufd_step (
    input  logic [ufd_pkg::ByteW-1:0] in_byte,
    input  ufd_pkg::ufd_state_t       state,
    input  ufd_pkg::ufd_held_t        held_bytes,
    output ufd_pkg::ufd_state_t       state_next,
    output ufd_pkg::ufd_step_t        step
);

    logic [ufd_pkg::LenW-1:0] held_plus1;
    logic [ufd_pkg::CpW-1:0]  cp2;
    logic [ufd_pkg::CpW-1:0]  cp3;
    logic [ufd_pkg::CpW-1:0]  cp4;
    logic [5:0]               c_bits;

    assign held_plus1 = {1'b0, state.bytes_held} + 3'd1;
    assign c_bits     = in_byte[5:0];

    assign cp2 = {10'd0, held_bytes[0][4:0], c_bits};
    assign cp3 = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], c_bits};
    assign cp4 = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0], c_bits};

    always_comb begin
        state_next      = state;
        step.emit       = 1'b0;
        step.code_point = {13'd0, in_byte};
        step.hb_we      = 1'b0;
        step.hb_idx     = state.bytes_held;

        if (!in_byte[7]) begin
            // ASCII: pass through, abort any open sequence
            state_next.bytes_held = '0;
            step.emit             = 1'b1;
        end else if (state.bytes_held == '0) begin
            if (in_byte[6]) begin
                step.hb_we  = 1'b1;
                step.hb_idx = '0;
                state_next.bytes_held = 2'd1;
                if (!in_byte[5]) begin
                    state_next.seq_len = ufd_pkg::SEQ_LEN_2;
                end else if (!in_byte[4]) begin
                    state_next.seq_len = ufd_pkg::SEQ_LEN_3;
                end else if (!in_byte[3]) begin
                    state_next.seq_len = ufd_pkg::SEQ_LEN_4;
                end else begin
                    state_next.bytes_held = '0;  // F8..FF dropped
                end
            end
        end else if (in_byte[6]) begin
            // lead byte inside a sequence: drop both
            state_next.bytes_held = '0;
        end else if (held_plus1 < state.seq_len) begin
            step.hb_we            = 1'b1;
            state_next.bytes_held = held_plus1[ufd_pkg::HeldW-1:0];
        end else begin
            state_next.bytes_held = '0;
            if (held_plus1 == state.seq_len) begin
                case (state.seq_len)
                    ufd_pkg::SEQ_LEN_2: begin
                        step.code_point = cp2;
                        step.emit       = (cp2 >= ufd_pkg::FLOOR_2);
                    end
                    ufd_pkg::SEQ_LEN_3: begin
                        step.code_point = cp3;
                        step.emit       = (cp3 >= ufd_pkg::FLOOR_3);
                    end
                    ufd_pkg::SEQ_LEN_4: begin
                        step.code_point = cp4;
                        step.emit       = (cp4 >= ufd_pkg::FLOOR_4);
                    end
                    default: begin
                        step.emit = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

FILE: hw/rtl/utf8_byte_stream_decoder_unit.sv
// Top level of the UTF-8 byte stream decoder: input register, decode, result register.
// Decodes one byte of a UTF-8 stream per item and gives a 21-bit code point when a
// sequence completes. Throughput is one byte per clock while m_ready does not hold
// back a waiting result. A byte is held in the input register, then its result is
// registered in the result register, which drives m_valid. The sequence state
// (bytes held, expected length, lead and continuation bytes) updates when a byte
// leaves the input register, so each byte sees the state left by the one before it.
// ASCII bytes pass through and abort an open sequence; F8..FF, stray continuation
// bytes, a lead byte inside an open sequence and overlong forms give no result.
// Surrogates and values above 10FFFF are emitted as decoded. Bytes that give no
// result still take one slot in the pipe but never reach the output. s_ready
// depends combinationally on m_ready when both registers are full.
module utf8_byte_stream_decoder_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ufd_pkg::ByteW-1:0] s_in_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ufd_pkg::CpW-1:0]   m_code_point
);

    // input register
    logic                      in_valid_reg;
    logic [ufd_pkg::ByteW-1:0] in_byte_reg;

    // sequence state
    ufd_pkg::ufd_state_t state_reg;
    ufd_pkg::ufd_state_t state_next;
    ufd_pkg::ufd_held_t  held_reg;

    // result register
    logic                    out_valid_reg;
    logic [ufd_pkg::CpW-1:0] code_point_reg;

    ufd_pkg::ufd_step_t step;
    logic               advance;
    logic               s_fire;

    // the byte in the input register moves on once the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign m_valid      = out_valid_reg;
    assign m_code_point = code_point_reg;

    ufd_step u_step (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .held_bytes (held_reg),
        .state_next (state_next),
        .step       (step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= step.emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_in_byte;
        end
        if (advance && step.emit) begin
            code_point_reg <= step.code_point;
        end
        if (advance && step.hb_we) begin
            case (step.hb_idx)
                2'd0:    held_reg[0] <= in_byte_reg;
                2'd1:    held_reg[1] <= in_byte_reg;
                2'd2:    held_reg[2] <= in_byte_reg;
                default: held_reg[0] <= held_reg[0];
            endcase
        end
    end

    // an open sequence always has a legal length and fewer held bytes than that length
    a_state_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.bytes_held != '0) |->
            ((state_reg.seq_len == ufd_pkg::SEQ_LEN_2 ||
              state_reg.seq_len == ufd_pkg::SEQ_LEN_3 ||
              state_reg.seq_len == ufd_pkg::SEQ_LEN_4) &&
             ({1'b0, state_reg.bytes_held} < state_reg.seq_len)))
        else $error("sequence state out of range");

    // an ASCII byte leaving the input register shows up unchanged on the output
    a_ascii_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_byte_reg[7]) |=>
            (m_valid && m_code_point == {13'd0, $past(in_byte_reg)} &&
             state_reg.bytes_held == '0))
        else $error("ASCII byte not passed through");

    // a result caused by a non-ASCII byte is never below 0x80
    a_no_overlong: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_byte_reg[7] && step.emit) |=> (m_code_point >= ufd_pkg::FLOOR_2))
        else $error("overlong result emitted");

    // a new result appears only when a byte has advanced out of the input register
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a decoded byte");

endmodule
